/* design/tcpw_pkg.sv */
// Shared widths, types and constants for the triangle closest point weight pipeline.
`timescale 1ns / 1ps
package tcpw_pkg;
	localparam int CW      = 32;
	localparam int DW      = CW + 1;
	localparam int LW      = 32;
	localparam int DPW     = 2 * DW + 2;
	localparam int PPW     = 2 * DPW;
	localparam int NW      = PPW + 3;
	localparam int QW      = 31;
	localparam int FW      = 32;
	localparam int MUL_LAT = 5;
	localparam int DOT_LAT = MUL_LAT + 1;
	localparam int DIV_LAT = FW + 2;

	localparam logic [QW-1:0] ONE_Q30 = QW'(32'h4000_0000);

	typedef logic signed [CW-1:0]  coord_t;
	typedef logic signed [DW-1:0]  crd_t;
	typedef logic signed [DPW-1:0] dot_t;
	typedef logic signed [NW-1:0]  num_t;
	typedef logic [QW-1:0]         wgt_t;

	typedef enum logic [1:0] {
		MODE_PLANE,
		MODE_EDGE_A,
		MODE_EDGE_B,
		MODE_EDGE_C
	} mode_t;

	typedef struct packed {
		logic  degen;
		mode_t mode;
	} ctl_t;
endpackage

/* design/tcpw_mul.sv */
// Pipelined signed multiplier built from 32x32 limb products.
`timescale 1ns / 1ps
module tcpw_mul #(
	parameter int WA = 33,
	parameter int WB = 33
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);
	import tcpw_pkg::*;

	localparam int NA = (WA + LW - 1) / LW;
	localparam int NB = (WB + LW - 1) / LW;
	localparam int PW = WA + WB;
	localparam int RW = (NB + 1) * LW;

	logic [WA-1:0]      abs_a;
	logic [WB-1:0]      abs_b;
	logic [NA*LW-1:0]   ma_s1;
	logic [NB*LW-1:0]   mb_s1;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2*LW-1:0]    pp_s2 [NA][NB];
	logic [RW-1:0]      row_c [NA];
	logic [RW-1:0]      row_s3 [NA];
	logic [PW-1:0]      sum_c;
	logic [PW-1:0]      sum_s4;
	logic signed [PW-1:0] p_s5;

	assign abs_a = a[WA-1] ? (~a + 1'b1) : a;
	assign abs_b = b[WB-1] ? (~b + 1'b1) : b;

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s2[i][j]) << (j * LW));
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (PW'(row_s3[i]) << (i * LW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= (NA*LW)'(abs_a);
			mb_s1  <= (NB*LW)'(abs_b);
			neg_s1 <= a[WA-1] ^ b[WB-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= ma_s1[i*LW +: LW] * mb_s1[j*LW +: LW];
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			sum_s4 <= sum_c;
			neg_s4 <= neg_s3;
			p_s5   <= neg_s4 ? (~sum_s4 + 1'b1) : sum_s4;
		end
	end

	assign p = p_s5;
endmodule

/* design/tcpw_dot3.sv */
// Pipelined three-term dot product of 33-bit signed vectors.
`timescale 1ns / 1ps
module tcpw_dot3 (
	input  logic           clk,
	input  logic           en,
	input  tcpw_pkg::crd_t a [3],
	input  tcpw_pkg::crd_t b [3],
	output tcpw_pkg::dot_t d
);
	import tcpw_pkg::*;

	logic signed [2*DW-1:0] prod [3];
	dot_t                   d_s1;

	for (genvar i = 0; i < 3; i++) begin : g_mul
		tcpw_mul #(.WA(DW), .WB(DW)) u_mul (
			.clk (clk),
			.en  (en),
			.a   (a[i]),
			.b   (b[i]),
			.p   (prod[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= DPW'(prod[0]) + DPW'(prod[1]) + DPW'(prod[2]);
		end
	end

	assign d = d_s1;
endmodule

/* design/tcpw_div.sv */
// Pipelined restoring divider giving a rounded, clamped Q1.30 ratio.
`timescale 1ns / 1ps
module tcpw_div (
	input  logic           clk,
	input  logic           en,
	input  tcpw_pkg::num_t n,
	input  tcpw_pkg::num_t d,
	output tcpw_pkg::wgt_t q
);
	import tcpw_pkg::*;

	localparam int XW = NW + FW;

	logic [XW-1:0] x_s  [FW+1];
	logic [NW-1:0] dv_s [FW+1];
	logic [FW-1:0] qb_s [FW+1];
	logic          neg_s [FW+1];
	logic          ge_s  [FW+1];
	wgt_t          q_q;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= (XW'($unsigned(n)) << (FW - 1)) + XW'($unsigned(d));
			dv_s[0]  <= d;
			qb_s[0]  <= '0;
			neg_s[0] <= n[NW-1];
			ge_s[0]  <= !n[NW-1] && (n >= d);
		end
	end

	for (genvar i = 1; i <= FW; i++) begin : g_stage
		localparam int K = FW - i;
		logic [XW-1:0] ys;
		logic          hit;

		assign ys  = XW'(dv_s[i-1]) << (K + 1);
		assign hit = x_s[i-1] >= ys;

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]   <= hit ? (x_s[i-1] - ys) : x_s[i-1];
				qb_s[i]  <= qb_s[i-1] | (FW'(hit) << K);
				dv_s[i]  <= dv_s[i-1];
				neg_s[i] <= neg_s[i-1];
				ge_s[i]  <= ge_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= neg_s[FW] ? '0 : (ge_s[FW] ? ONE_Q30 : qb_s[FW][QW-1:0]);
		end
	end

	assign q = q_q;
endmodule

/* design/tcpw_dly.sv */
// Enabled delay line that keeps side data aligned with the arithmetic stages.
`timescale 1ns / 1ps
module tcpw_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] d_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			d_q[0] <= din;
			for (int i = 1; i < N; i++) begin
				d_q[i] <= d_q[i-1];
			end
		end
	end

	assign dout = d_q[N-1];
endmodule

/* design/triangle_closest_point_weights.sv */
// Top level: closest point on a triangle as barycentric weights, fully pipelined.
// Accepts one request per clock and returns one result per request, in order. Most of
// the pipeline depth comes from the exact wide products (two rounds of limb multipliers)
// and the 32-stage one-bit-per-stage divider that forms the Q1.30 quotients. The whole
// pipeline holds while a result waits unaccepted at the output.
`timescale 1ns / 1ps
module triangle_closest_point_weights (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tcpw_pkg::coord_t   point_x,
	input  tcpw_pkg::coord_t   point_y,
	input  tcpw_pkg::coord_t   point_z,
	input  tcpw_pkg::coord_t   vertex_a_x,
	input  tcpw_pkg::coord_t   vertex_a_y,
	input  tcpw_pkg::coord_t   vertex_a_z,
	input  tcpw_pkg::coord_t   vertex_b_x,
	input  tcpw_pkg::coord_t   vertex_b_y,
	input  tcpw_pkg::coord_t   vertex_b_z,
	input  tcpw_pkg::coord_t   vertex_c_x,
	input  tcpw_pkg::coord_t   vertex_c_y,
	input  tcpw_pkg::coord_t   vertex_c_z,
	output logic               out_valid,
	input  logic               out_ready,
	output tcpw_pkg::wgt_t     weight_a,
	output tcpw_pkg::wgt_t     weight_b,
	output tcpw_pkg::wgt_t     weight_c,
	output logic               degenerate
);
	import tcpw_pkg::*;

	localparam int S_NA = 1 + DOT_LAT + MUL_LAT + 2;
	localparam int LAT  = S_NA + DIV_LAT + 1;

	function automatic crd_t dif(input coord_t x, input coord_t y);
		return DW'(x) - DW'(y);
	endfunction

	logic           en;
	logic [LAT-1:0] vld_q;

	coord_t pt [3];
	coord_t va [3];
	coord_t vb [3];
	coord_t vc [3];

	crd_t u_s1 [3];
	crd_t v_s1 [3];
	crd_t w_s1 [3];
	crd_t pb_s1 [3];
	crd_t cb_s1 [3];
	crd_t pc_s1 [3];
	crd_t ac_s1 [3];

	dot_t d00, d01, d11, d20, d21, e1n, e1d, e2n, e2d;
	dot_t e1n_d, e1d_d, e2n_d, e2d_d, e3n_d, e3d_d;
	logic [6*DPW-1:0] edg_raw;

	logic signed [PPW-1:0] pr [6];
	num_t den_s13, nb_s13, nc_s13;
	num_t na_s14, den_s14, nb_s14, nc_s14;

	ctl_t ctl_c;
	ctl_t ctl_d;
	logic [$bits(ctl_t)-1:0] ctl_raw;
	num_t n0, d0;
	wgt_t q0, q1, q2;

	wgt_t wa_q, wb_q, wc_q;
	logic dg_q;

	assign pt = '{point_x, point_y, point_z};
	assign va = '{vertex_a_x, vertex_a_y, vertex_a_z};
	assign vb = '{vertex_b_x, vertex_b_y, vertex_b_z};
	assign vc = '{vertex_c_x, vertex_c_y, vertex_c_z};

	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s1[i]  <= dif(vb[i], va[i]);
				v_s1[i]  <= dif(vc[i], va[i]);
				w_s1[i]  <= dif(pt[i], va[i]);
				pb_s1[i] <= dif(pt[i], vb[i]);
				cb_s1[i] <= dif(vc[i], vb[i]);
				pc_s1[i] <= dif(pt[i], vc[i]);
				ac_s1[i] <= dif(va[i], vc[i]);
			end
		end
	end

	tcpw_dot3 u_d00 (.clk(clk), .en(en), .a(u_s1),  .b(u_s1),  .d(d00));
	tcpw_dot3 u_d01 (.clk(clk), .en(en), .a(u_s1),  .b(v_s1),  .d(d01));
	tcpw_dot3 u_d11 (.clk(clk), .en(en), .a(v_s1),  .b(v_s1),  .d(d11));
	tcpw_dot3 u_d20 (.clk(clk), .en(en), .a(w_s1),  .b(u_s1),  .d(d20));
	tcpw_dot3 u_d21 (.clk(clk), .en(en), .a(w_s1),  .b(v_s1),  .d(d21));
	tcpw_dot3 u_e1n (.clk(clk), .en(en), .a(pb_s1), .b(cb_s1), .d(e1n));
	tcpw_dot3 u_e1d (.clk(clk), .en(en), .a(cb_s1), .b(cb_s1), .d(e1d));
	tcpw_dot3 u_e2n (.clk(clk), .en(en), .a(pc_s1), .b(ac_s1), .d(e2n));
	tcpw_dot3 u_e2d (.clk(clk), .en(en), .a(ac_s1), .b(ac_s1), .d(e2d));

	tcpw_mul #(.WA(DPW), .WB(DPW)) u_m0 (.clk(clk), .en(en), .a(d00), .b(d11), .p(pr[0]));
	tcpw_mul #(.WA(DPW), .WB(DPW)) u_m1 (.clk(clk), .en(en), .a(d01), .b(d01), .p(pr[1]));
	tcpw_mul #(.WA(DPW), .WB(DPW)) u_m2 (.clk(clk), .en(en), .a(d11), .b(d20), .p(pr[2]));
	tcpw_mul #(.WA(DPW), .WB(DPW)) u_m3 (.clk(clk), .en(en), .a(d01), .b(d21), .p(pr[3]));
	tcpw_mul #(.WA(DPW), .WB(DPW)) u_m4 (.clk(clk), .en(en), .a(d00), .b(d21), .p(pr[4]));
	tcpw_mul #(.WA(DPW), .WB(DPW)) u_m5 (.clk(clk), .en(en), .a(d01), .b(d20), .p(pr[5]));

	tcpw_dly #(.W(6*DPW), .N(MUL_LAT + 2)) u_edg_dly (
		.clk  (clk),
		.en   (en),
		.din  ({e1n, e1d, e2n, e2d, d20, d00}),
		.dout (edg_raw)
	);
	assign {e1n_d, e1d_d, e2n_d, e2d_d, e3n_d, e3d_d} = edg_raw;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s13 <= NW'(pr[0]) - NW'(pr[1]);
			nb_s13  <= NW'(pr[2]) - NW'(pr[3]);
			nc_s13  <= NW'(pr[4]) - NW'(pr[5]);
			na_s14  <= den_s13 - nb_s13 - nc_s13;
			den_s14 <= den_s13;
			nb_s14  <= nb_s13;
			nc_s14  <= nc_s13;
		end
	end

	always_comb begin
		ctl_c.degen = den_s14[NW-1] || (den_s14 == '0);
		if (na_s14[NW-1]) begin
			ctl_c.mode = MODE_EDGE_A;
			n0 = NW'(e1n_d);
			d0 = NW'(e1d_d);
		end else if (nb_s14[NW-1]) begin
			ctl_c.mode = MODE_EDGE_B;
			n0 = NW'(e2n_d);
			d0 = NW'(e2d_d);
		end else if (nc_s14[NW-1]) begin
			ctl_c.mode = MODE_EDGE_C;
			n0 = NW'(e3n_d);
			d0 = NW'(e3d_d);
		end else begin
			ctl_c.mode = MODE_PLANE;
			n0 = na_s14;
			d0 = den_s14;
		end
	end

	tcpw_div u_div0 (.clk(clk), .en(en), .n(n0),     .d(d0),      .q(q0));
	tcpw_div u_div1 (.clk(clk), .en(en), .n(nb_s14), .d(den_s14), .q(q1));
	tcpw_div u_div2 (.clk(clk), .en(en), .n(nc_s14), .d(den_s14), .q(q2));

	tcpw_dly #(.W($bits(ctl_t)), .N(DIV_LAT)) u_ctl_dly (
		.clk  (clk),
		.en   (en),
		.din  (ctl_c),
		.dout (ctl_raw)
	);
	assign ctl_d = ctl_t'(ctl_raw);

	always_ff @(posedge clk) begin
		if (en) begin
			dg_q <= ctl_d.degen;
			if (ctl_d.degen) begin
				wa_q <= '0;
				wb_q <= '0;
				wc_q <= '0;
			end else begin
				case (ctl_d.mode)
					MODE_EDGE_A: begin
						wa_q <= '0;
						wb_q <= ONE_Q30 - q0;
						wc_q <= q0;
					end
					MODE_EDGE_B: begin
						wa_q <= q0;
						wb_q <= '0;
						wc_q <= ONE_Q30 - q0;
					end
					MODE_EDGE_C: begin
						wa_q <= ONE_Q30 - q0;
						wb_q <= q0;
						wc_q <= '0;
					end
					default: begin
						wa_q <= q0;
						wb_q <= q1;
						wc_q <= q2;
					end
				endcase
			end
		end
	end

	assign weight_a   = wa_q;
	assign weight_b   = wb_q;
	assign weight_c   = wc_q;
	assign degenerate = dg_q;
endmodule

/* dv/tb.sv */
// Testbench for triangle_closest_point_weights: directed and random triangles vs. a local predictor.
`timescale 1ns / 1ps
module tb;
	import tcpw_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 120;
	localparam int Q1 = 32'sh0001_0000;

	typedef logic signed [191:0] big_t;

	typedef struct {
		coord_t p[3];
		coord_t a[3];
		coord_t b[3];
		coord_t c[3];
	} tri_t;

	typedef struct packed {
		wgt_t wa;
		wgt_t wb;
		wgt_t wc;
		logic degen;
	} weights_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	coord_t point_x, point_y, point_z;
	coord_t vertex_a_x, vertex_a_y, vertex_a_z;
	coord_t vertex_b_x, vertex_b_y, vertex_b_z;
	coord_t vertex_c_x, vertex_c_y, vertex_c_z;
	wgt_t weight_a, weight_b, weight_c;
	logic degenerate;

	weights_t pending_weights[$];
	int errors = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int degen_seen = 0;
	int cycles = 0;
	bit calm = 0;
	int stall_left = 0;

	triangle_closest_point_weights uut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic big_t dot3(big_t x[3], big_t y[3]);
		big_t s;
		s = 0;
		for (int i = 0; i < 3; i++) s += x[i] * y[i];
		return s;
	endfunction

	function automatic wgt_t ratio_q30(big_t n, big_t d);
		logic [191:0] num, den, q;
		if (n < 0) return '0;
		if (n >= d) return ONE_Q30;
		num = (n <<< 31) + d;
		den = d <<< 1;
		q = num / den;
		return wgt_t'(q);
	endfunction

	function automatic wgt_t edge_param(coord_t p[3], coord_t x[3], coord_t y[3]);
		big_t px[3], e[3];
		for (int i = 0; i < 3; i++) begin
			px[i] = big_t'(p[i]) - big_t'(x[i]);
			e[i] = big_t'(y[i]) - big_t'(x[i]);
		end
		return ratio_q30(dot3(px, e), dot3(e, e));
	endfunction

	function automatic weights_t closest_weights(tri_t q);
		big_t u[3], v[3], w[3];
		big_t d00, d01, d11, d20, d21, den, nb, nc, na;
		weights_t r;
		wgt_t t;
		for (int i = 0; i < 3; i++) begin
			u[i] = big_t'(q.b[i]) - big_t'(q.a[i]);
			v[i] = big_t'(q.c[i]) - big_t'(q.a[i]);
			w[i] = big_t'(q.p[i]) - big_t'(q.a[i]);
		end
		d00 = dot3(u, u);
		d01 = dot3(u, v);
		d11 = dot3(v, v);
		d20 = dot3(w, u);
		d21 = dot3(w, v);
		den = d00 * d11 - d01 * d01;
		r = '0;
		if (den <= 0) begin
			r.degen = 1'b1;
			return r;
		end
		nb = d11 * d20 - d01 * d21;
		nc = d00 * d21 - d01 * d20;
		na = den - nb - nc;
		if (na < 0) begin
			t = edge_param(q.p, q.b, q.c);
			r.wb = ONE_Q30 - t;
			r.wc = t;
		end else if (nb < 0) begin
			t = edge_param(q.p, q.c, q.a);
			r.wa = t;
			r.wc = ONE_Q30 - t;
		end else if (nc < 0) begin
			t = edge_param(q.p, q.a, q.b);
			r.wa = ONE_Q30 - t;
			r.wb = t;
		end else begin
			r.wa = ratio_q30(na, den);
			r.wb = ratio_q30(nb, den);
			r.wc = ratio_q30(nc, den);
		end
		return r;
	endfunction

	function automatic tri_t mk(int px, int py, int pz, int ax, int ay, int az,
			int bx, int by, int bz, int cx, int cy, int cz);
		tri_t q;
		q.p = '{px, py, pz};
		q.a = '{ax, ay, az};
		q.b = '{bx, by, bz};
		q.c = '{cx, cy, cz};
		return q;
	endfunction

	task automatic send_request(tri_t q);
		int gap;
		gap = 0;
		point_x <= q.p[0]; point_y <= q.p[1]; point_z <= q.p[2];
		vertex_a_x <= q.a[0]; vertex_a_y <= q.a[1]; vertex_a_z <= q.a[2];
		vertex_b_x <= q.b[0]; vertex_b_y <= q.b[1]; vertex_b_z <= q.b[2];
		vertex_c_x <= q.c[0]; vertex_c_y <= q.c[1]; vertex_c_z <= q.c[2];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_weights.insert(pending_weights.size(), closest_weights(q));
		requests_sent++;
		if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		weights_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{weight_a, weight_b, weight_c, degenerate};
			if (pending_weights.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_weights.pop_front();
				results_checked++;
				if (want.degen) degen_seen++;
				if (got.wa !== want.wa) begin
					$display("%0t: weight_a expected %h actual %h", $time, want.wa, got.wa);
					errors++;
				end
				if (got.wb !== want.wb) begin
					$display("%0t: weight_b expected %h actual %h", $time, want.wb, got.wb);
					errors++;
				end
				if (got.wc !== want.wc) begin
					$display("%0t: weight_c expected %h actual %h", $time, want.wc, got.wc);
					errors++;
				end
				if (got.degen !== want.degen) begin
					$display("%0t: degenerate expected %b actual %b", $time, want.degen,
						got.degen);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic coord_t rand_coord(int bits);
		if (bits >= 32) return coord_t'($urandom);
		return coord_t'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
	endfunction

	function automatic tri_t rand_tri();
		tri_t q;
		int bits, sel, k;
		sel = $urandom_range(0, 99);
		bits = (sel < 20) ? 32 : (sel < 35) ? 5 : $urandom_range(12, 26);
		for (int i = 0; i < 3; i++) begin
			q.p[i] = rand_coord(bits);
			q.a[i] = rand_coord(bits);
			q.b[i] = rand_coord(bits);
			q.c[i] = rand_coord(bits);
		end
		if (sel >= 90) begin
			k = $urandom_range(0, 3) - 1;
			for (int i = 0; i < 3; i++) begin
				q.b[i] = q.a[i] + rand_coord(10);
				q.c[i] = q.a[i] + k * (q.b[i] - q.a[i]);
			end
		end else if (sel >= 85) begin
			for (int i = 0; i < 3; i++) q.p[i] = q.b[i] + rand_coord(3);
		end
		return q;
	endfunction

	task automatic wait_drained();
		while (pending_weights.size() != 0) @(posedge clk);
	endtask

	task automatic test_plane_regions();
		send_request(mk(Q1/4, Q1/4, Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(0, 0, 0, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(Q1/2, 0, -Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(Q1/3, Q1/3, 0, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(Q1, Q1, 0, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(-Q1, Q1/2, 0, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(Q1/2, -Q1, 0, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(-Q1, -Q1, 0, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(3*Q1, -Q1, 0, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(-Q1, 3*Q1, 2*Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
		send_request(mk(2*Q1, 2*Q1, 0, 0, 0, 0, Q1, 0, 0, 0, Q1, 0));
	endtask

	task automatic test_degenerate();
		send_request(mk(Q1, 2, 3, 5, 5, 5, 5, 5, 5, 5, 5, 5));
		send_request(mk(0, Q1, 0, 0, 0, 0, Q1, Q1, Q1, 2*Q1, 2*Q1, 2*Q1));
		send_request(mk(7, 7, 7, 0, 0, 0, Q1, 0, 0, Q1, 0, 0));
	endtask

	task automatic test_extremes();
		int mx, mn;
		mx = 32'sh7fff_ffff;
		mn = 32'sh8000_0000;
		send_request(mk(mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn));
		send_request(mk(mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mx));
		send_request(mk(0, 0, mx, mn, mn, 0, mx, mn, 0, 0, mx, 0));
		send_request(mk(mx, mn, 0, mn, mn, mn, mn, mn, mn, mn, mn, mn));
		send_request(mk(mn, mx, mn, mx, mx, mx, mx, mx, mx, mx, mx, mx));
		send_request(mk(-1, -1, -1, mx, 0, 0, 0, mx, 0, 0, 0, mx));
		send_request(mk(mx, mx, mx, mn, 0, 0, 0, mn, 0, 0, 0, mn));
	endtask

	task automatic test_drain_pause();
		in_valid <= 1'b0;
		wait_drained();
		repeat (20) send_request(rand_tri());
		in_valid <= 1'b0;
		wait_drained();
	endtask

	task automatic test_random_mix(int n);
		repeat (n) send_request(rand_tri());
	endtask

	task automatic test_streaming(int n);
		calm = 1;
		repeat (n) send_request(rand_tri());
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		{point_x, point_y, point_z} = '0;
		{vertex_a_x, vertex_a_y, vertex_a_z} = '0;
		{vertex_b_x, vertex_b_y, vertex_b_z} = '0;
		{vertex_c_x, vertex_c_y, vertex_c_z} = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plane_regions();
		test_degenerate();
		test_extremes();
		test_random_mix(350);
		test_drain_pause();
		test_random_mix(330);
		test_streaming(100);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests, checked %0d results (%0d degenerate triangles),",
			requests_sent, results_checked, degen_seen);
		$display("covering plane and clamped-edge regions, extreme coordinates and stalls.");
		if (errors == 0 && pending_weights.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

/* sim.f */
design/tcpw_pkg.sv
design/tcpw_mul.sv
design/tcpw_dot3.sv
design/tcpw_div.sv
design/tcpw_dly.sv
design/triangle_closest_point_weights.sv
dv/tb.sv
